FILE: hdl/pfb_pkg.sv
// Package for the position frame builder: frame layout constants, item types
// and the bytewise CRC-8 step. Has no dependencies of its own.
`default_nettype none

package pfb_pkg;

	// Frame layout.
	localparam int unsigned FrameBytes = 19;
	localparam int unsigned BodyBytes  = 13;
	localparam int unsigned IdxW       = 5;
	localparam int unsigned BodyIdxW   = 4;

	// Byte positions inside the frame.
	localparam logic [IdxW-1:0] PosHdr0 = 5'd0;
	localparam logic [IdxW-1:0] PosHdr1 = 5'd1;
	localparam logic [IdxW-1:0] PosLen  = 5'd2;
	localparam logic [IdxW-1:0] PosBody = 5'd3;
	localparam logic [IdxW-1:0] PosCrc  = 5'd16;
	localparam logic [IdxW-1:0] PosTrl0 = 5'd17;
	localparam logic [IdxW-1:0] PosTrl1 = 5'd18;

	// Fixed frame bytes.
	localparam logic [7:0] Hdr0       = 8'h55;
	localparam logic [7:0] Hdr1       = 8'hAA;
	localparam logic [7:0] PayloadLen = 8'd13;
	localparam logic [7:0] Trl0       = 8'h0D;
	localparam logic [7:0] Trl1       = 8'h0A;
	localparam logic [7:0] CrcPoly    = 8'h8C;

	// Default depth of the queue between front and back.
	localparam int unsigned QueueDepthDefault = 2;

	// Payload bytes 3 to 15 of a frame, element 0 is frame byte 3.
	typedef logic [BodyBytes-1:0][7:0] body_t;

	// Reflected CRC-8 over one byte, one polynomial step per bit.
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/pfb_in_if.sv
// Input channel of the position frame builder: six coordinates and a
// control byte with a valid/ready handshake. Depends on nothing.
`default_nettype none

interface pfb_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic        [7:0]  control_byte;

	modport source (
		output valid, left_x, left_y, center_x, center_y, right_x, right_y, control_byte,
		input  ready
	);
	modport sink (
		input  valid, left_x, left_y, center_x, center_y, right_x, right_y, control_byte,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/pfb_out_if.sv
// Output channel of the position frame builder: one frame byte and a last
// flag with a valid/ready handshake. Depends on nothing.
`default_nettype none

interface pfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (
		output valid, frame_byte, frame_last,
		input  ready
	);
	modport sink (
		input  valid, frame_byte, frame_last,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/pfb_front.sv
// Front end: accepts position transactions, packs them into frame payload
// bytes and holds them in a small queue. Depends on pfb_pkg and pfb_in_if.
`default_nettype none

module pfb_front
	import pfb_pkg::*;
#(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pfb_in_if.sink    pos_in,
	output logic      q_valid,
	output body_t     q_body,
	input  wire logic q_pop
);

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

	body_t           mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	body_t           packed_body;
	logic            push;
	logic            pop;

	// Lay the coordinates out low byte first, control byte last.
	always_comb begin
		packed_body[0]  = pos_in.left_x[7:0];
		packed_body[1]  = pos_in.left_x[15:8];
		packed_body[2]  = pos_in.left_y[7:0];
		packed_body[3]  = pos_in.left_y[15:8];
		packed_body[4]  = pos_in.center_x[7:0];
		packed_body[5]  = pos_in.center_x[15:8];
		packed_body[6]  = pos_in.center_y[7:0];
		packed_body[7]  = pos_in.center_y[15:8];
		packed_body[8]  = pos_in.right_x[7:0];
		packed_body[9]  = pos_in.right_x[15:8];
		packed_body[10] = pos_in.right_y[7:0];
		packed_body[11] = pos_in.right_y[15:8];
		packed_body[12] = pos_in.control_byte;
	end

	// Handshakes on both sides of the queue.
	assign pos_in.ready = (count_q != FullCnt);
	assign push         = pos_in.valid && pos_in.ready;
	assign q_valid      = (count_q != '0);
	assign pop          = q_pop && q_valid;
	assign q_body       = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= packed_body;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pfb_back.sv
// Back end: walks one frame byte per cycle unless the output stalls, folds
// bytes 0 to 15 into the CRC, drives the output register. Depends on pfb_pkg, pfb_out_if.
`default_nettype none

module pfb_back
	import pfb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  wire body_t  q_body,
	output logic        q_pop,
	pfb_out_if.source   frame_out
);

	body_t               body_q;
	logic                busy_q;
	logic [IdxW-1:0]     idx_q;
	logic [7:0]          crc_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;
	logic                advance;
	logic                emit;
	logic                at_last;
	logic [7:0]          cur_byte;
	logic [BodyIdxW-1:0] body_idx;

	assign advance = !out_valid_q || frame_out.ready;
	assign emit    = advance && busy_q;
	assign at_last = (idx_q == PosTrl1);
	assign q_pop   = advance && (!busy_q || at_last);
	assign body_idx = BodyIdxW'(idx_q - PosBody);

	// Pick the byte at the current frame position.
	always_comb begin
		case (idx_q)
			PosHdr0: cur_byte = Hdr0;
			PosHdr1: cur_byte = Hdr1;
			PosLen:  cur_byte = PayloadLen;
			PosCrc:  cur_byte = crc_q;
			PosTrl0: cur_byte = Trl0;
			PosTrl1: cur_byte = Trl1;
			default: cur_byte = body_q[body_idx];
		endcase
	end

	// Load the next payload when a frame ends or the back end is idle.
	always_ff @(posedge clk) begin
		if (q_pop && q_valid) begin
			body_q <= q_body;
		end
		if (emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= at_last;
		end
	end

	// Sequencer, CRC register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (emit) begin
				if (idx_q == PosHdr0) begin
					crc_q <= crc_byte(8'h00, cur_byte);
				end else if (idx_q < PosCrc) begin
					crc_q <= crc_byte(crc_q, cur_byte);
				end
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
			if (q_pop) begin
				busy_q <= q_valid;
			end
		end
	end

	assign frame_out.valid      = out_valid_q;
	assign frame_out.frame_byte = out_byte_q;
	assign frame_out.frame_last = out_last_q;

endmodule

`default_nettype wire

FILE: hdl/position_frame_builder_crc8.sv
// Position frame builder with CRC-8: top level joining the front queue and
// the back-end serializer. Depends on pfb_pkg, pfb_in_if, pfb_out_if.
// With the back end idle and the output free, an accepted transaction passes through the queue,
// the back-end payload register and the output register before its first frame byte is valid.
// One frame byte per cycle leaves through the output register while the output is ready.
// Frames follow each other without a gap while the queue holds a next transaction.
// Reset clears the queue pointers, the sequencer, the CRC register and the output valid.
`default_nettype none

module position_frame_builder_crc8
	import pfb_pkg::*;
#(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pfb_in_if.sink    pos_in,
	pfb_out_if.source frame_out
);

	logic  q_valid;
	logic  q_pop;
	body_t q_body;

	// Front end with the transaction queue.
	pfb_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pos_in (pos_in),
		.q_valid(q_valid),
		.q_body (q_body),
		.q_pop  (q_pop)
	);

	// Back end serializer.
	pfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_body   (q_body),
		.q_pop    (q_pop),
		.frame_out(frame_out)
	);

endmodule

`default_nettype wire
